>>> src/ppusr_pkg.sv
package ppusr_pkg;

   // Operation codes carried by req_op.
   localparam logic [2:0] OP_REG_WRITE    = 3'd0;
   localparam logic [2:0] OP_REG_READ     = 3'd1;
   localparam logic [2:0] OP_COARSE_X     = 3'd2;
   localparam logic [2:0] OP_Y_STEP       = 3'd3;
   localparam logic [2:0] OP_VBLANK_START = 3'd4;
   localparam logic [2:0] OP_VBLANK_END   = 3'd5;

   // Register numbers carried by req_reg_select.
   localparam logic [2:0] REG_CONTROL     = 3'd0;
   localparam logic [2:0] REG_MASK        = 3'd1;
   localparam logic [2:0] REG_STATUS      = 3'd2;
   localparam logic [2:0] REG_SPRITE_ADDR = 3'd3;
   localparam logic [2:0] REG_SPRITE_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL      = 3'd5;
   localparam logic [2:0] REG_ADDRESS     = 3'd6;
   localparam logic [2:0] REG_DATA        = 3'd7;

   localparam int SPRITE_RAM_DEPTH = 256;
   localparam int SPRITE_ADDR_WIDTH = $clog2(SPRITE_RAM_DEPTH);

   // Coarse y values at which the vertical step wraps.
   localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
   localparam logic [4:0] COARSE_Y_MAX      = 5'd31;

   typedef struct packed {
      logic [14:0]                  cur_addr;
      logic [14:0]                  tmp_addr;
      logic [2:0]                   fine_x;
      logic                         write_toggle;
      logic [7:0]                   ctrl;
      logic [7:0]                   mask;
      logic [7:0]                   status;
      logic [SPRITE_ADDR_WIDTH-1:0] sprite_addr;
   } regs_type;

   typedef struct packed {
      logic [7:0]  status_data;
      logic        sprite_read;
      logic [14:0] current_addr;
      logic [2:0]  fine_x_out;
      logic [13:0] mem_addr;
      logic        mem_write;
      logic        mem_read;
      logic [7:0]  mem_data;
      logic        nmi;
      logic [1:0]  render_enable;
   } rsp_type;

endpackage

>>> src/ppusr_ram.sv
module ppusr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ppusr_next.sv
module ppusr_next (
   input  logic [2:0]          op,
   input  logic [2:0]          reg_select,
   input  logic [7:0]          write_data,
   input  ppusr_pkg::regs_type cur,
   output ppusr_pkg::regs_type nxt,
   output ppusr_pkg::rsp_type  res,
   output logic                sprite_we,
   output logic                sprite_re
);

   logic [14:0] data_step_addr;
   logic [14:0] coarse_x_addr;
   logic [14:0] y_addr;
   logic [14:0] y_wrap;

   assign data_step_addr = cur.cur_addr + (cur.ctrl[2] ? 15'd32 : 15'd1);

   always_comb begin
      if (cur.cur_addr[4:0] == 5'h1F) begin
         coarse_x_addr = {cur.cur_addr[14:11], ~cur.cur_addr[10], cur.cur_addr[9:5], 5'd0};
      end else begin
         coarse_x_addr = cur.cur_addr + 15'd1;
      end
   end

   // Fine y rolls into coarse y; coarse y wraps at the last tile row and
   // flips the vertical table bit there, but not past the attribute rows.
   always_comb begin
      y_wrap = {3'b000, cur.cur_addr[11:0]};
      if (cur.cur_addr[14:12] != 3'b111) begin
         y_addr = cur.cur_addr + 15'h1000;
      end else if (y_wrap[9:5] == ppusr_pkg::COARSE_Y_LAST_ROW) begin
         y_addr = {y_wrap[14:12], ~y_wrap[11], y_wrap[10], 5'd0, y_wrap[4:0]};
      end else if (y_wrap[9:5] == ppusr_pkg::COARSE_Y_MAX) begin
         y_addr = {y_wrap[14:10], 5'd0, y_wrap[4:0]};
      end else begin
         y_addr = y_wrap + 15'h0020;
      end
   end

   always_comb begin
      nxt       = cur;
      res       = '0;
      sprite_we = 1'b0;
      sprite_re = 1'b0;
      case (op)
         ppusr_pkg::OP_REG_WRITE: begin
            case (reg_select)
               ppusr_pkg::REG_CONTROL: begin
                  nxt.ctrl            = write_data;
                  nxt.tmp_addr[11:10] = write_data[1:0];
               end
               ppusr_pkg::REG_MASK: begin
                  nxt.mask = write_data;
               end
               ppusr_pkg::REG_SPRITE_ADDR: begin
                  nxt.sprite_addr = write_data;
               end
               ppusr_pkg::REG_SPRITE_DATA: begin
                  sprite_we       = 1'b1;
                  nxt.sprite_addr = cur.sprite_addr + 8'd1;
               end
               ppusr_pkg::REG_SCROLL: begin
                  if (cur.write_toggle) begin
                     nxt.tmp_addr = {write_data[2:0], cur.tmp_addr[11:10], write_data[7:3],
                                     cur.tmp_addr[4:0]};
                     nxt.write_toggle = 1'b0;
                  end else begin
                     nxt.fine_x        = write_data[2:0];
                     nxt.tmp_addr[4:0] = write_data[7:3];
                     nxt.write_toggle  = 1'b1;
                  end
               end
               ppusr_pkg::REG_ADDRESS: begin
                  if (cur.write_toggle) begin
                     nxt.tmp_addr     = {cur.tmp_addr[14:8], write_data};
                     nxt.cur_addr     = {cur.tmp_addr[14:8], write_data};
                     nxt.write_toggle = 1'b0;
                  end else begin
                     nxt.tmp_addr     = {1'b0, write_data[5:0], cur.tmp_addr[7:0]};
                     nxt.write_toggle = 1'b1;
                  end
               end
               ppusr_pkg::REG_DATA: begin
                  res.mem_addr  = cur.cur_addr[13:0];
                  res.mem_write = 1'b1;
                  res.mem_data  = write_data;
                  nxt.cur_addr  = data_step_addr;
               end
               default: begin
               end
            endcase
         end
         ppusr_pkg::OP_REG_READ: begin
            case (reg_select)
               ppusr_pkg::REG_STATUS: begin
                  res.status_data  = cur.status;
                  nxt.status[7]    = 1'b0;
                  nxt.write_toggle = 1'b0;
               end
               ppusr_pkg::REG_SPRITE_DATA: begin
                  res.sprite_read = 1'b1;
                  sprite_re       = 1'b1;
               end
               ppusr_pkg::REG_DATA: begin
                  res.mem_addr = cur.cur_addr[13:0];
                  res.mem_read = 1'b1;
                  nxt.cur_addr = data_step_addr;
               end
               default: begin
               end
            endcase
         end
         ppusr_pkg::OP_COARSE_X: begin
            nxt.cur_addr = coarse_x_addr;
         end
         ppusr_pkg::OP_Y_STEP: begin
            nxt.cur_addr = y_addr;
         end
         ppusr_pkg::OP_VBLANK_START: begin
            nxt.status[7] = 1'b1;
            res.nmi       = cur.ctrl[7];
         end
         ppusr_pkg::OP_VBLANK_END: begin
            nxt.status[7] = 1'b0;
         end
         default: begin
         end
      endcase
      res.current_addr  = nxt.cur_addr;
      res.fine_x_out    = nxt.fine_x;
      res.render_enable = nxt.mask[4:3];
   end

endmodule

>>> src/ppu_scroll_register_unit_core.sv
// Path: an accepted request goes first to the staging register, where it waits while the
// sprite RAM read completes, and then to the output register.
// Throughput: one request per cycle while responses are taken; the output register and the
// staging register let a new request in while a finished response waits for rsp_ready.
// Reset clears all scroll, control, mask, status and sprite address registers and the
// pipeline valid bits; sprite RAM contents stay undefined until written.
module ppu_scroll_register_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [2:0]  req_reg_select,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic [14:0] rsp_current_addr,
   output logic [2:0]  rsp_fine_x_out,
   output logic [13:0] rsp_mem_addr,
   output logic        rsp_mem_write,
   output logic        rsp_mem_read,
   output logic [7:0]  rsp_mem_data,
   output logic        rsp_nmi,
   output logic [1:0]  rsp_render_enable
);

   ppusr_pkg::regs_type regs_ff;
   ppusr_pkg::regs_type regs_in;
   ppusr_pkg::rsp_type  step_res;
   ppusr_pkg::rsp_type  s1_ff;
   ppusr_pkg::rsp_type  out_ff;
   logic                s1_valid_ff;
   logic                out_valid_ff;
   logic [7:0]          out_read_data_ff;
   logic [7:0]          out_read_data_in;
   logic                sprite_we;
   logic                sprite_re;
   logic [7:0]          sprite_rd_data;
   logic                accept;
   logic                s1_move;

   // The staging register only moves on when the output register is free, so the
   // sprite RAM read data stays put while a request waits there.
   assign s1_move   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   ppusr_next u_next (
      .op         (req_op),
      .reg_select (req_reg_select),
      .write_data (req_write_data),
      .cur        (regs_ff),
      .nxt        (regs_in),
      .res        (step_res),
      .sprite_we  (sprite_we),
      .sprite_re  (sprite_re)
   );

   ppusr_ram #(
      .WIDTH (8),
      .DEPTH (ppusr_pkg::SPRITE_RAM_DEPTH)
   ) u_sprite_ram (
      .clock   (clock),
      .wr_en   (accept && sprite_we),
      .wr_addr (regs_ff.sprite_addr),
      .wr_data (req_write_data),
      .rd_en   (accept && sprite_re),
      .rd_addr (regs_ff.sprite_addr),
      .rd_data (sprite_rd_data)
   );

   assign out_read_data_in = s1_ff.sprite_read ? sprite_rd_data : s1_ff.status_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            regs_ff <= regs_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= step_res;
      end
      if (s1_move) begin
         out_ff           <= s1_ff;
         out_read_data_ff <= out_read_data_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = out_read_data_ff;
   assign rsp_current_addr  = out_ff.current_addr;
   assign rsp_fine_x_out    = out_ff.fine_x_out;
   assign rsp_mem_addr      = out_ff.mem_addr;
   assign rsp_mem_write     = out_ff.mem_write;
   assign rsp_mem_read      = out_ff.mem_read;
   assign rsp_mem_data      = out_ff.mem_data;
   assign rsp_nmi           = out_ff.nmi;
   assign rsp_render_enable = out_ff.render_enable;

endmodule

>>> tb/ppu_scroll_register_unit_core_test.sv
module ppu_scroll_register_unit_core_test;

   // Operation codes that the block treats as no-ops.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int RANDOM_REQUESTS = 1650;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [14:0] current_addr;
      logic [2:0]  fine_x_out;
      logic [13:0] mem_addr;
      logic        mem_write;
      logic        mem_read;
      logic [7:0]  mem_data;
      logic        nmi;
      logic [1:0]  render_enable;
   } scroll_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_op = '0;
   logic [2:0]  req_reg_select = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [14:0] rsp_current_addr;
   logic [2:0]  rsp_fine_x_out;
   logic [13:0] rsp_mem_addr;
   logic        rsp_mem_write;
   logic        rsp_mem_read;
   logic [7:0]  rsp_mem_data;
   logic        rsp_nmi;
   logic [1:0]  rsp_render_enable;

   // Shadow copy of the register file, advanced once per accepted request.
   logic [14:0] vram_addr = '0;
   logic [14:0] vram_latch = '0;
   logic [2:0]  fine_scroll_x = '0;
   logic        latch_phase = 1'b0;
   logic [7:0]  ctrl_byte = '0;
   logic [7:0]  mask_byte = '0;
   logic [7:0]  status_byte = '0;
   logic [7:0]  oam_addr = '0;
   logic [7:0]  oam_bytes [ppusr_pkg::SPRITE_RAM_DEPTH];
   bit          oam_written [ppusr_pkg::SPRITE_RAM_DEPTH];

   scroll_result_type pending_results[$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   bit          steady_flow = 1'b0;
   int unsigned stall_left = 0;

   ppu_scroll_register_unit_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_reg_select(req_reg_select),
      .req_write_data(req_write_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_current_addr(rsp_current_addr),
      .rsp_fine_x_out(rsp_fine_x_out),
      .rsp_mem_addr(rsp_mem_addr),
      .rsp_mem_write(rsp_mem_write),
      .rsp_mem_read(rsp_mem_read),
      .rsp_mem_data(rsp_mem_data),
      .rsp_nmi(rsp_nmi),
      .rsp_render_enable(rsp_render_enable)
   );

   always #6 clock = ~clock;

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic void advance_data_addr();
      vram_addr = vram_addr + (ctrl_byte[2] ? 15'd32 : 15'd1);
   endfunction

   function automatic scroll_result_type predict_access(logic [2:0] op, logic [2:0] sel,
                                                        logic [7:0] data);
      scroll_result_type r;
      r = '0;
      case (op)
         ppusr_pkg::OP_REG_WRITE: begin
            case (sel)
               ppusr_pkg::REG_CONTROL: begin
                  ctrl_byte = data;
                  vram_latch[11:10] = data[1:0];
               end
               ppusr_pkg::REG_MASK: mask_byte = data;
               ppusr_pkg::REG_SPRITE_ADDR: oam_addr = data;
               ppusr_pkg::REG_SPRITE_DATA: begin
                  oam_bytes[oam_addr] = data;
                  oam_written[oam_addr] = 1'b1;
                  oam_addr = oam_addr + 8'd1;
               end
               ppusr_pkg::REG_SCROLL: begin
                  if (latch_phase) begin
                     vram_latch[14:12] = data[2:0];
                     vram_latch[9:5] = data[7:3];
                  end else begin
                     fine_scroll_x = data[2:0];
                     vram_latch[4:0] = data[7:3];
                  end
                  latch_phase = ~latch_phase;
               end
               ppusr_pkg::REG_ADDRESS: begin
                  if (latch_phase) begin
                     vram_latch[7:0] = data;
                     vram_addr = vram_latch;
                  end else begin
                     vram_latch[13:8] = data[5:0];
                     vram_latch[14] = 1'b0;
                  end
                  latch_phase = ~latch_phase;
               end
               ppusr_pkg::REG_DATA: begin
                  r.mem_addr = vram_addr[13:0];
                  r.mem_write = 1'b1;
                  r.mem_data = data;
                  advance_data_addr();
               end
               default: ;
            endcase
         end
         ppusr_pkg::OP_REG_READ: begin
            case (sel)
               ppusr_pkg::REG_STATUS: begin
                  r.read_data = status_byte;
                  status_byte[7] = 1'b0;
                  latch_phase = 1'b0;
               end
               ppusr_pkg::REG_SPRITE_DATA: r.read_data = oam_bytes[oam_addr];
               ppusr_pkg::REG_DATA: begin
                  r.mem_addr = vram_addr[13:0];
                  r.mem_read = 1'b1;
                  advance_data_addr();
               end
               default: ;
            endcase
         end
         ppusr_pkg::OP_COARSE_X: begin
            if (vram_addr[4:0] == 5'h1F) begin
               vram_addr[4:0] = '0;
               vram_addr[10] = ~vram_addr[10];
            end else begin
               vram_addr[4:0] = vram_addr[4:0] + 5'd1;
            end
         end
         ppusr_pkg::OP_Y_STEP: begin
            if (vram_addr[14:12] != 3'd7) begin
               vram_addr[14:12] = vram_addr[14:12] + 3'd1;
            end else begin
               vram_addr[14:12] = '0;
               if (vram_addr[9:5] == ppusr_pkg::COARSE_Y_LAST_ROW) begin
                  vram_addr[9:5] = '0;
                  vram_addr[11] = ~vram_addr[11];
               end else if (vram_addr[9:5] == ppusr_pkg::COARSE_Y_MAX) begin
                  vram_addr[9:5] = '0;
               end else begin
                  vram_addr[9:5] = vram_addr[9:5] + 5'd1;
               end
            end
         end
         ppusr_pkg::OP_VBLANK_START: begin
            status_byte[7] = 1'b1;
            r.nmi = ctrl_byte[7];
         end
         ppusr_pkg::OP_VBLANK_END: status_byte[7] = 1'b0;
         default: ;
      endcase
      r.current_addr = vram_addr;
      r.fine_x_out = fine_scroll_x;
      r.render_enable = mask_byte[4:3];
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input logic [2:0] op, input logic [2:0] sel,
                               input logic [7:0] data);
      int unsigned gap;
      // Sprite RAM entries that were never written must not be read back.
      if (op == ppusr_pkg::OP_REG_READ && sel == ppusr_pkg::REG_SPRITE_DATA &&
          !oam_written[oam_addr])
         op = ppusr_pkg::OP_REG_WRITE;
      gap = steady_flow ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_reg_select <= sel;
      req_write_data <= data;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_access(op, sel, data));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic compare_field(input string label, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t %s: expected 0x%0h, actual 0x%0h", $time, label, want, got);
      end
   endtask

   always @(negedge clock) begin
      if (steady_flow || stall_left == 0) begin
         rsp_ready <= 1'b1;
         if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end else begin
         rsp_ready <= 1'b0;
         stall_left--;
      end
   end

   always @(posedge clock) begin : check_responses
      scroll_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t response with no request outstanding: current_addr 0x%0h",
                     $time, rsp_current_addr);
         end else begin
            want = pending_results.pop_front();
            compare_field("read_data", 32'(want.read_data), 32'(rsp_read_data));
            compare_field("current_addr", 32'(want.current_addr), 32'(rsp_current_addr));
            compare_field("fine_x_out", 32'(want.fine_x_out), 32'(rsp_fine_x_out));
            compare_field("mem_addr", 32'(want.mem_addr), 32'(rsp_mem_addr));
            compare_field("mem_write", 32'(want.mem_write), 32'(rsp_mem_write));
            compare_field("mem_read", 32'(want.mem_read), 32'(rsp_mem_read));
            compare_field("mem_data", 32'(want.mem_data), 32'(rsp_mem_data));
            compare_field("nmi", 32'(want.nmi), 32'(rsp_nmi));
            compare_field("render_enable", 32'(want.render_enable),
                          32'(rsp_render_enable));
         end
      end
   end

   // Status writes are dropped, and reads of write-only registers return zero.
   task automatic test_register_reads();
      send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_STATUS, 8'hFF);
      send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_STATUS, 8'h00);
      send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_CONTROL, 8'hFF);
      send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_MASK, 8'h00);
      send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_SPRITE_ADDR, 8'h00);
      send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_SCROLL, 8'h00);
      send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_ADDRESS, 8'h00);
   endtask

   task automatic test_vblank_nmi();
      send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_CONTROL, 8'h84);
      send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_MASK, 8'h18);
      send_request(ppusr_pkg::OP_VBLANK_START, ppusr_pkg::REG_CONTROL, 8'h00);
      send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_STATUS, 8'hFF);
      send_request(ppusr_pkg::OP_VBLANK_END, ppusr_pkg::REG_DATA, 8'hFF);
   endtask

   task automatic test_scroll_latch();
      send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_SCROLL, 8'hFF);
      send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_SCROLL, 8'h00);
      send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_DATA, 8'h00);
   endtask

   // Y steps push the address past bit 13, then a data access wraps it in 15 bits.
   task automatic test_address_wrap();
      send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_ADDRESS, 8'hFF);
      send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_ADDRESS, 8'hFF);
      repeat (4) send_request(ppusr_pkg::OP_Y_STEP, ppusr_pkg::REG_STATUS, 8'h00);
      send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_DATA, 8'hA5);
      send_request(ppusr_pkg::OP_COARSE_X, ppusr_pkg::REG_MASK, 8'h00);
   endtask

   task automatic test_sprite_ram();
      send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_SPRITE_ADDR, 8'hFF);
      send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_SPRITE_DATA, 8'h5A);
      send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_SPRITE_ADDR, 8'hFF);
      send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_SPRITE_DATA, 8'h00);
   endtask

   task automatic test_spare_ops();
      send_request(OP_SPARE_6, ppusr_pkg::REG_DATA, 8'hFF);
      send_request(OP_SPARE_7, ppusr_pkg::REG_CONTROL, 8'h00);
   endtask

   task automatic test_random_traffic();
      int unsigned first, kind, run, pick, base, count;
      first = items_sent;
      while (items_sent - first < RANDOM_REQUESTS) begin
         steady_flow = (items_sent - first >= 600) && (items_sent - first < 850);
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            // Frame setup as software does it, then a run of render-time steps.
            send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_STATUS,
                         8'($urandom_range(0, 255)));
            send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_SCROLL,
                         8'($urandom_range(0, 255)));
            send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_SCROLL,
                         8'($urandom_range(0, 255)));
            send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_ADDRESS,
                         8'($urandom_range(0, 255)));
            send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_ADDRESS,
                         8'($urandom_range(0, 255)));
            run = $urandom_range(1, 40);
            repeat (run) begin
               pick = $urandom_range(0, 9);
               if (pick < 4)
                  send_request(ppusr_pkg::OP_COARSE_X, 3'($urandom_range(0, 7)),
                               8'($urandom_range(0, 255)));
               else if (pick < 8)
                  send_request(ppusr_pkg::OP_Y_STEP, 3'($urandom_range(0, 7)),
                               8'($urandom_range(0, 255)));
               else
                  send_request(pick[0] ? ppusr_pkg::OP_REG_WRITE : ppusr_pkg::OP_REG_READ,
                               ppusr_pkg::REG_DATA, 8'($urandom_range(0, 255)));
            end
         end else if (kind < 60) begin
            base = $urandom_range(0, 255);
            count = $urandom_range(1, 8);
            send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_SPRITE_ADDR, 8'(base));
            repeat (count)
               send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_SPRITE_DATA,
                            8'($urandom_range(0, 255)));
            send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_SPRITE_ADDR,
                         8'(base + $urandom_range(0, count - 1)));
            repeat ($urandom_range(1, 3))
               send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_SPRITE_DATA,
                            8'($urandom_range(0, 255)));
         end else if (kind < 72) begin
            send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_CONTROL,
                         8'($urandom_range(0, 255)));
            send_request(ppusr_pkg::OP_REG_WRITE, ppusr_pkg::REG_MASK,
                         8'($urandom_range(0, 255)));
            send_request(ppusr_pkg::OP_VBLANK_START, 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
               send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_STATUS, 8'h00);
            send_request(ppusr_pkg::OP_VBLANK_END, 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)));
            send_request(ppusr_pkg::OP_REG_READ, ppusr_pkg::REG_STATUS,
                         8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 10))
               send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                            8'($urandom_range(0, 255)));
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_register_reads();
      test_vblank_nmi();
      test_scroll_latch();
      test_address_wrap();
      test_sprite_ram();
      test_spare_ops();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #12_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
